>>> rtl/aptq_pkg.sv
package aptq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_QUEUES  = 4;
    localparam int TAG_W       = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int QIDX_W      = 2;
    localparam int TOTAL_W     = CNT_W + QIDX_W;
    localparam int OUT_TOTAL_W = 7;
    localparam int KIND_W      = 2;

    // Input word kinds
    localparam logic [KIND_W-1:0] KIND_SUBMIT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd2;

    // Queue numbering, in scan order
    localparam logic [QIDX_W-1:0] Q_MAIN_HIGH = 2'd0;
    localparam logic [QIDX_W-1:0] Q_MAIN_LOW  = 2'd1;
    localparam logic [QIDX_W-1:0] Q_GEN_HIGH  = 2'd2;
    localparam logic [QIDX_W-1:0] Q_GEN_LOW   = 2'd3;

    // Per-queue control from the top level
    typedef struct packed {
        logic             push;
        logic             pop;
        logic             clear;
        logic [TAG_W-1:0] tag;
    } t_fifo_ctrl;

    // Per-cell control inside a queue
    typedef struct packed {
        logic             shift;
        logic             load;
        logic [TAG_W-1:0] tag;
    } t_cell_ctrl;

endpackage

>>> rtl/aptq_cell.sv
module aptq_cell (
    input  logic                      i_clk,
    input  aptq_pkg::t_cell_ctrl      i_ctrl,
    input  logic [aptq_pkg::TAG_W-1:0] i_next_tag,
    output logic [aptq_pkg::TAG_W-1:0] o_tag
);
    import aptq_pkg::*;

    logic [TAG_W-1:0] r_tag;

    // Pop moves every entry one cell towards the head; push fills the free cell
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_tag <= i_next_tag;
        end else if (i_ctrl.load) begin
            r_tag <= i_ctrl.tag;
        end
    end

    assign o_tag = r_tag;

endmodule

>>> rtl/aptq_fifo.sv
module aptq_fifo (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  aptq_pkg::t_fifo_ctrl       i_ctrl,
    output logic [aptq_pkg::TAG_W-1:0] o_head,
    output logic [aptq_pkg::CNT_W-1:0] o_count
);
    import aptq_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [TAG_W-1:0] w_tag [QUEUE_DEPTH];

    // Fill count; clear wins, push and pop never come together
    always_comb begin
        n_count = r_count;
        if (i_ctrl.clear) begin
            n_count = '0;
        end else if (i_ctrl.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_ctrl.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Chain of cells, cell 0 holds the head
    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        t_cell_ctrl       w_ctrl;
        logic [TAG_W-1:0] w_next;

        assign w_ctrl.shift = i_ctrl.pop;
        assign w_ctrl.load  = i_ctrl.push && (r_count == CNT_W'(k));
        assign w_ctrl.tag   = i_ctrl.tag;

        if (k == QUEUE_DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_tag[k+1];
        end

        aptq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_next_tag (w_next),
            .o_tag      (w_tag[k])
        );
    end

    assign o_head  = w_tag[0];
    assign o_count = r_count;

endmodule

>>> rtl/affinity_priority_task_queue.sv
// Four task queues (main-high, main-low, general-high, general-low) with
// affinity routing and priority pop.
// Input channel (i_in_valid / o_in_ready): one word per item; i_kind picks
// submit, worker request or clear. Every word gives exactly one result word.
// Output channel (o_out_valid / i_out_ready): the result sits in an output
// register and appears the cycle after the input word is taken.
// Throughput is one word per cycle: a push, a pop or a clear completes in the
// cycle the word is taken, and each queue is a chain of cells whose head is
// always cell 0, so no read port limits the rate.
// When the receiver stalls, the input side keeps taking words only once the
// output register has been taken or is taken in the same cycle.
// Config channel (i_cfg_valid / o_cfg_ready): always ready; writes the
// enable bit. While disabled, worker requests come back halted; submits are
// still stored.
// Reset empties every queue, zeroes the total and clears the enable bit;
// stored tags themselves are not cleared and need no clearing pass.
module affinity_priority_task_queue (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic                             i_cfg_system_enabled,
    // input words
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [aptq_pkg::KIND_W-1:0]      i_kind,
    input  logic [aptq_pkg::TAG_W-1:0]       i_task_id,
    input  logic                             i_needs_main,
    input  logic                             i_needs_gpu,
    input  logic                             i_urgent,
    input  logic                             i_worker_is_main,
    // result words
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_granted,
    output logic [aptq_pkg::TAG_W-1:0]       o_task_out,
    output logic [aptq_pkg::QIDX_W-1:0]      o_queue_index,
    output logic                             o_accepted,
    output logic [aptq_pkg::OUT_TOTAL_W-1:0] o_queued_total,
    output logic                             o_halted
);
    import aptq_pkg::*;

    logic               r_enabled;
    logic [TOTAL_W-1:0] r_total;
    logic [TOTAL_W-1:0] n_total;
    logic               r_out_valid;

    logic                   r_granted,  n_granted;
    logic [TAG_W-1:0]       r_task_out, n_task_out;
    logic [QIDX_W-1:0]      r_qidx,     n_qidx;
    logic                   r_accepted, n_accepted;
    logic                   r_halted,   n_halted;
    logic [OUT_TOTAL_W-1:0] r_queued;

    logic                   w_fire;
    logic [QIDX_W-1:0]      w_sub_q;
    logic [QIDX_W-1:0]      w_pick;
    logic                   w_any;
    logic [NUM_QUEUES-1:0]  w_nonempty;
    t_fifo_ctrl             w_ctrl  [NUM_QUEUES];
    logic [TAG_W-1:0]       w_head  [NUM_QUEUES];
    logic [CNT_W-1:0]       w_count [NUM_QUEUES];

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_fire      = i_in_valid && o_in_ready;

    // The four queues
    for (genvar q = 0; q < NUM_QUEUES; q++) begin : g_queue
        aptq_fifo u_fifo (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl[q]),
            .o_head  (w_head[q]),
            .o_count (w_count[q])
        );
        assign w_nonempty[q] = (w_count[q] != '0);
    end

    // Submit routing: main queues for main or GPU work, low bit for low priority
    assign w_sub_q = {!(i_needs_main || i_needs_gpu), !i_urgent};

    // Request scan in priority order; general workers skip the main queues
    always_comb begin
        w_any  = 1'b1;
        w_pick = Q_GEN_LOW;
        if (i_worker_is_main && w_nonempty[Q_MAIN_HIGH]) begin
            w_pick = Q_MAIN_HIGH;
        end else if (i_worker_is_main && w_nonempty[Q_MAIN_LOW]) begin
            w_pick = Q_MAIN_LOW;
        end else if (w_nonempty[Q_GEN_HIGH]) begin
            w_pick = Q_GEN_HIGH;
        end else if (!w_nonempty[Q_GEN_LOW]) begin
            w_any = 1'b0;
        end
    end

    // Item decode: queue controls and the next result word
    always_comb begin
        for (int q = 0; q < NUM_QUEUES; q++) begin
            w_ctrl[q].push  = 1'b0;
            w_ctrl[q].pop   = 1'b0;
            w_ctrl[q].clear = 1'b0;
            w_ctrl[q].tag   = i_task_id;
        end
        n_granted  = 1'b0;
        n_task_out = '0;
        n_qidx     = Q_MAIN_HIGH;
        n_accepted = 1'b0;
        n_halted   = 1'b0;
        n_total    = r_total;
        if (w_fire) begin
            unique case (i_kind)
                KIND_SUBMIT: begin
                    n_qidx = w_sub_q;
                    if (w_count[w_sub_q] != CNT_W'(QUEUE_DEPTH)) begin
                        w_ctrl[w_sub_q].push = 1'b1;
                        n_accepted           = 1'b1;
                        n_total              = r_total + TOTAL_W'(1);
                    end
                end
                KIND_REQUEST: begin
                    if (!r_enabled) begin
                        n_halted = 1'b1;
                    end else if (w_any) begin
                        w_ctrl[w_pick].pop = 1'b1;
                        n_granted          = 1'b1;
                        n_task_out         = w_head[w_pick];
                        n_qidx             = w_pick;
                        n_total            = r_total - TOTAL_W'(1);
                    end
                end
                KIND_CLEAR: begin
                    for (int q = 0; q < NUM_QUEUES; q++) begin
                        w_ctrl[q].clear = 1'b1;
                    end
                    n_total = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_enabled <= i_cfg_system_enabled;
            end
            r_total <= n_total;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_granted  <= n_granted;
            r_task_out <= n_task_out;
            r_qidx     <= n_qidx;
            r_accepted <= n_accepted;
            r_halted   <= n_halted;
            r_queued   <= n_total[OUT_TOTAL_W-1:0];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_granted      = r_granted;
    assign o_task_out     = r_task_out;
    assign o_queue_index  = r_qidx;
    assign o_accepted     = r_accepted;
    assign o_queued_total = r_queued;
    assign o_halted       = r_halted;

`ifndef SYNTHESIS
    a_total_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total == TOTAL_W'(w_count[0]) + TOTAL_W'(w_count[1])
                 + TOTAL_W'(w_count[2]) + TOTAL_W'(w_count[3]))
        else $error("running total disagrees with queue counts");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count[0] <= CNT_W'(QUEUE_DEPTH) && w_count[1] <= CNT_W'(QUEUE_DEPTH)
        && w_count[2] <= CNT_W'(QUEUE_DEPTH) && w_count[3] <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_grant_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_granted && (o_halted || o_accepted)))
        else $error("grant reported together with halt or accept");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && i_kind == KIND_REQUEST && r_enabled && w_any |-> w_nonempty[w_pick])
        else $error("pop from an empty queue");
`endif

endmodule
